// ===== hdl/fdes_pkg.sv =====
package fdes_pkg;

    localparam int unsigned NameLen   = 11;
    localparam int unsigned EntryLen  = 32;
    localparam int unsigned PosW      = $clog2(EntryLen);
    localparam int unsigned CfgIdxW   = 8;
    localparam int unsigned CfgDataW  = 64;

    localparam logic [7:0] MarkEnd     = 8'h00;
    localparam logic [7:0] MarkDeleted = 8'hE5;
    localparam logic [7:0] AttrLfn     = 8'h0F;
    localparam logic [7:0] AttrVolume  = 8'h08;

    localparam logic [CfgIdxW-1:0] RegNameLow  = CfgIdxW'(0);
    localparam logic [CfgIdxW-1:0] RegNameHigh = CfgIdxW'(1);

    localparam logic [PosW-1:0] PosFirst    = PosW'(0);
    localparam logic [PosW-1:0] PosAttr     = PosW'(NameLen);
    localparam logic [PosW-1:0] PosClus2    = PosW'(20);
    localparam logic [PosW-1:0] PosClus3    = PosW'(21);
    localparam logic [PosW-1:0] PosClus0    = PosW'(26);
    localparam logic [PosW-1:0] PosClus1    = PosW'(27);
    localparam logic [PosW-1:0] PosSize0    = PosW'(28);
    localparam logic [PosW-1:0] PosSize1    = PosW'(29);
    localparam logic [PosW-1:0] PosSize2    = PosW'(30);
    localparam logic [PosW-1:0] PosLast     = PosW'(EntryLen - 1);

    localparam logic STATUS_FOUND = 1'b0;
    localparam logic STATUS_END   = 1'b1;

    // One classified directory byte, front to back.
    typedef struct packed {
        logic [PosW-1:0] pos;
        logic [7:0]      data;
        logic            restart;
        logic            is_end;     // byte 0 of entry is the end marker
        logic            deleted;    // byte 0 of entry is the deleted marker
        logic            attr_skip;  // attribute byte marks LFN or volume label
        logic            mismatch;   // name byte differs from target
    } fdes_item_t;

    function automatic logic [7:0] target_char(input logic [63:0] low,
                                               input logic [23:0] high,
                                               input logic [3:0]  idx);
        logic [7:0] c;
        c = 8'h00;
        case (idx)
            4'd0:    c = low[7:0];
            4'd1:    c = low[15:8];
            4'd2:    c = low[23:16];
            4'd3:    c = low[31:24];
            4'd4:    c = low[39:32];
            4'd5:    c = low[47:40];
            4'd6:    c = low[55:48];
            4'd7:    c = low[63:56];
            4'd8:    c = high[7:0];
            4'd9:    c = high[15:8];
            4'd10:   c = high[23:16];
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== hdl/fdes_front.sv =====
module fdes_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    input  logic [fdes_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fdes_pkg::CfgDataW-1:0] cfg_data,
    input  logic                          in_fire,
    input  logic [7:0]                    in_byte,
    input  logic                          in_restart,
    output fdes_pkg::fdes_item_t          item
);

    logic [63:0]                 name_low_reg;
    logic [23:0]                 name_high_reg;
    logic [fdes_pkg::PosW-1:0]   pos_reg;
    logic [fdes_pkg::PosW-1:0]   pos_cur;
    logic [7:0]                  tgt;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_low_reg  <= '0;
            name_high_reg <= '0;
            pos_reg       <= '0;
        end else begin
            if (cfg_valid && cfg_index == fdes_pkg::RegNameLow) begin
                name_low_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == fdes_pkg::RegNameHigh) begin
                name_high_reg <= cfg_data[23:0];
            end
            if (in_fire) begin
                pos_reg <= pos_cur + fdes_pkg::PosW'(1);
            end
        end
    end

    // restart forces this byte to be byte 0 of an entry
    assign pos_cur = in_restart ? fdes_pkg::PosFirst : pos_reg;
    assign tgt     = fdes_pkg::target_char(name_low_reg, name_high_reg, pos_cur[3:0]);

    always_comb begin
        item           = '0;
        item.pos       = pos_cur;
        item.data      = in_byte;
        item.restart   = in_restart;
        item.is_end    = (pos_cur == fdes_pkg::PosFirst) && (in_byte == fdes_pkg::MarkEnd);
        item.deleted   = (pos_cur == fdes_pkg::PosFirst) && (in_byte == fdes_pkg::MarkDeleted);
        item.attr_skip = (pos_cur == fdes_pkg::PosAttr)
                         && ((in_byte == fdes_pkg::AttrLfn)
                             || ((in_byte & fdes_pkg::AttrVolume) != 8'h00));
        item.mismatch  = (pos_cur < fdes_pkg::PosAttr) && (in_byte != tgt);
    end

endmodule

// ===== hdl/fdes_queue.sv =====
module fdes_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  fdes_pkg::fdes_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output fdes_pkg::fdes_item_t pop_item
);

    fdes_pkg::fdes_item_t slot_reg [2];
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;
    logic [1:0]           count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = slot_reg[rd_ptr_reg];

endmodule

// ===== hdl/fdes_back.sv =====
module fdes_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_not_empty,
    input  fdes_pkg::fdes_item_t q_item,
    output logic                 q_pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [63:0]          m_tdata,
    output logic                 m_tuser
);

    logic        match_reg, match_next;
    logic        skip_reg, skip_next;
    logic [31:0] clus_reg, clus_next;
    logic [31:0] size_reg, size_next;
    logic        done_reg, done_next;
    logic        res_valid_reg;
    logic        res_status_reg;
    logic [31:0] res_clus_reg;
    logic [31:0] res_size_reg;

    logic        fire_res;
    logic        res_status;
    logic        done_eff;

    // pop whenever the result register can take a word this cycle
    assign q_pop = q_not_empty && (!res_valid_reg || m_tready);

    always_comb begin
        match_next = match_reg;
        skip_next  = skip_reg;
        clus_next  = clus_reg;
        size_next  = size_reg;
        fire_res   = 1'b0;
        res_status = fdes_pkg::STATUS_FOUND;
        done_eff   = q_item.restart ? 1'b0 : done_reg;
        done_next  = done_eff;
        if (!done_eff) begin
            if (q_item.pos == fdes_pkg::PosFirst) begin
                match_next = 1'b1;
                skip_next  = 1'b0;
                clus_next  = '0;
                size_next  = '0;
            end
            match_next = match_next & ~q_item.mismatch;
            skip_next  = skip_next | q_item.deleted | q_item.attr_skip;
            case (q_item.pos)
                fdes_pkg::PosClus2: clus_next[23:16] = q_item.data;
                fdes_pkg::PosClus3: clus_next[31:24] = q_item.data;
                fdes_pkg::PosClus0: clus_next[7:0]   = q_item.data;
                fdes_pkg::PosClus1: clus_next[15:8]  = q_item.data;
                fdes_pkg::PosSize0: size_next[7:0]   = q_item.data;
                fdes_pkg::PosSize1: size_next[15:8]  = q_item.data;
                fdes_pkg::PosSize2: size_next[23:16] = q_item.data;
                fdes_pkg::PosLast:  size_next[31:24] = q_item.data;
                default: ;
            endcase
            if (q_item.is_end) begin
                fire_res   = 1'b1;
                res_status = fdes_pkg::STATUS_END;
                clus_next  = '0;
                size_next  = '0;
                done_next  = 1'b1;
            end else if (q_item.pos == fdes_pkg::PosLast && !skip_next && match_next) begin
                fire_res   = 1'b1;
                res_status = fdes_pkg::STATUS_FOUND;
                done_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg      <= 1'b1;
            skip_reg       <= 1'b0;
            clus_reg       <= '0;
            size_reg       <= '0;
            done_reg       <= 1'b0;
            res_valid_reg  <= 1'b0;
            res_status_reg <= fdes_pkg::STATUS_FOUND;
        end else begin
            if (q_pop && fire_res) begin
                res_valid_reg <= 1'b1;
            end else if (m_tready) begin
                res_valid_reg <= 1'b0;
            end
            if (q_pop) begin
                match_reg <= match_next;
                skip_reg  <= skip_next;
                clus_reg  <= clus_next;
                size_reg  <= size_next;
                done_reg  <= done_next;
                if (fire_res) begin
                    res_status_reg <= res_status;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && fire_res) begin
            res_clus_reg <= clus_next;
            res_size_reg <= size_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = res_status_reg;
    assign m_tdata  = {res_size_reg, res_clus_reg};

endmodule

// ===== hdl/fat32_directory_entry_search_unit.sv =====
// FAT32 short-name directory search.
// Input stream (s_*): one directory byte per word; s_tuser set marks a restart,
// which clears the search and makes that byte byte 0 of the first entry.
// Config channel (cfg_*): index 0 writes target name bytes 0..7, index 1 bytes
// 8..10 (low 24 bits); other indexes are dropped. cfg_ready is always high;
// write only while the search is idle.
// Output stream (m_*): at most one word per search. m_tuser is the status
// (0 found, 1 end of directory), m_tdata holds start cluster and file size,
// both zero on end of directory. After a result, bytes are dropped until a
// restart.
// Throughput: one byte per cycle while the queue is not full. A result is registered
// after the byte that ends the entry (front classify -> queue -> back -> out reg).
// Reset clears the search state, the queue, the name registers and m_tvalid.
// When m_tready is low a pending result holds; the back end stops draining the
// two-entry queue while it holds, and s_tready drops once the queue is full, so no byte is lost.
module fat32_directory_entry_search_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config write channel
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [fdes_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [fdes_pkg::CfgDataW-1:0] cfg_data,
    // directory byte stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] entry_byte
    input  logic                          s_tuser,   // [0] restart
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // [31:0] first_cluster, [63:32] file_size
    output logic                          m_tuser    // [0] status
);

    fdes_pkg::fdes_item_t front_item;
    fdes_pkg::fdes_item_t back_item;
    logic                 q_full;
    logic                 q_not_empty;
    logic                 q_pop;
    logic                 in_fire;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_full;
    assign in_fire   = s_tvalid && !q_full;

    // front: position tracking and per-byte classification
    fdes_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_fire    (in_fire),
        .in_byte    (s_tdata),
        .in_restart (s_tuser),
        .item       (front_item)
    );

    // decoupling queue between classify and match/collect
    fdes_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_fire),
        .push_item (front_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_item  (back_item)
    );

    // back: match state, field collection, result register
    fdes_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_item      (back_item),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

// ===== tb/fat32_directory_entry_search_unit_tb.sv =====
module fat32_directory_entry_search_unit_tb;

    // Run bounds: the worst case, with both sides idling plus the deliberate
    // hold-off, stays far below this.
    localparam int unsigned CycleLimit   = 400000;
    localparam int unsigned SettleCycles = 8;    // covers the pipeline plus a 2-word queue
    localparam int unsigned MaxGap       = 18;
    localparam int unsigned LongHold     = 300;  // receiver hold-off to fill the block
    localparam int unsigned PhaseBytes   = 260;  // bytes offered per name setting

    localparam logic [fdes_pkg::CfgIdxW-1:0] RegUnmapped = '1;

    // "README  TXT", byte 0 in the low bits
    localparam logic [63:0] ReadmeLow  = 64'h2020_454D_4441_4552;
    localparam logic [23:0] ReadmeHigh = 24'h54_58_54;

    typedef enum {
        ENT_MATCH,    // name equals target, plain file attribute
        ENT_NEAR,     // one name bit flipped
        ENT_DELETED,  // matching name, deleted marker in byte 0
        ENT_LFN,      // matching name, long-name attribute
        ENT_VOLUME,   // matching name, volume-label bit set
        ENT_RANDOM,   // random bytes
        ENT_END       // end-of-directory marker in byte 0
    } entry_kind_t;

    typedef struct {
        logic        status;
        logic [31:0] cluster;
        logic [31:0] size;
    } lookup_t;

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [fdes_pkg::CfgIdxW-1:0]  cfg_index = '0;
    logic [fdes_pkg::CfgDataW-1:0] cfg_data  = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = '0;
    logic                          s_tuser   = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [63:0]                   m_tdata;
    logic                          m_tuser;

    fat32_directory_entry_search_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow of the search: target name, entry walk and pending lookups.
    logic [63:0]               name_low    = '0;
    logic [23:0]               name_high   = '0;
    logic [fdes_pkg::PosW-1:0] byte_pos    = '0;
    bit                        name_ok     = 1'b1;
    bit                        entry_skip  = 1'b0;
    logic [31:0]               cluster_acc = '0;
    logic [31:0]               size_acc    = '0;
    bit                        search_over = 1'b0;
    lookup_t                   lookup_q[$];

    int unsigned items_sent  = 0;
    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;
    int unsigned hold_req    = 0;   // set by a test, consumed by the result sink
    bit          tx_idle     = 1'b1;
    bit          rx_idle     = 1'b1;

    logic [7:0] entry_buf [fdes_pkg::EntryLen];

    initial begin : clock_gen
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    function automatic logic [7:0] name_char(int unsigned i);
        if (i < 8) return name_low[8*i +: 8];
        return name_high[8*(i-8) +: 8];
    endfunction

    // Advance the shadow search by one accepted byte, queueing any lookup result.
    function automatic void predict_byte(logic [7:0] b, logic rs);
        logic [fdes_pkg::PosW-1:0] p;
        if (rs) begin
            byte_pos    = '0;
            search_over = 1'b0;
        end
        if (search_over) return;   // dropped until the next restart
        p = byte_pos;
        if (p == fdes_pkg::PosFirst) begin
            name_ok     = 1'b1;
            entry_skip  = 1'b0;
            cluster_acc = '0;
            size_acc    = '0;
            if (b == fdes_pkg::MarkEnd) begin
                search_over = 1'b1;
                lookup_q.push_back('{fdes_pkg::STATUS_END, 32'd0, 32'd0});
                return;
            end
            if (b == fdes_pkg::MarkDeleted) entry_skip = 1'b1;
        end
        if (p < fdes_pkg::NameLen && b != name_char(p)) name_ok = 1'b0;
        if (p == fdes_pkg::PosAttr
            && (b == fdes_pkg::AttrLfn || (b & fdes_pkg::AttrVolume) != 0)) entry_skip = 1'b1;
        case (p)
            fdes_pkg::PosClus2: cluster_acc[23:16] = b;
            fdes_pkg::PosClus3: cluster_acc[31:24] = b;
            fdes_pkg::PosClus0: cluster_acc[7:0]   = b;
            fdes_pkg::PosClus1: cluster_acc[15:8]  = b;
            fdes_pkg::PosSize0: size_acc[7:0]      = b;
            fdes_pkg::PosSize1: size_acc[15:8]     = b;
            fdes_pkg::PosSize2: size_acc[23:16]    = b;
            fdes_pkg::PosLast:  size_acc[31:24]    = b;
            default: ;
        endcase
        byte_pos = p + 1'b1;   // wraps 31 -> 0
        if (p == fdes_pkg::PosLast && !entry_skip && name_ok) begin
            search_over = 1'b1;
            lookup_q.push_back('{fdes_pkg::STATUS_FOUND, cluster_acc, size_acc});
        end
    endfunction

    // Fill entry_buf with one 32-byte directory entry of the given kind.
    function automatic void build_entry(entry_kind_t kind, logic [31:0] clus,
                                        logic [31:0] fsize);
        int unsigned idx;
        foreach (entry_buf[i]) entry_buf[i] = 8'($urandom);
        if (kind != ENT_RANDOM && kind != ENT_END) begin
            for (int i = 0; i < fdes_pkg::NameLen; i++) entry_buf[i] = name_char(i);
            entry_buf[fdes_pkg::PosAttr] = 8'($urandom) & ~fdes_pkg::AttrVolume;
        end
        case (kind)
            ENT_NEAR: begin
                idx = $urandom_range(0, fdes_pkg::NameLen - 1);
                entry_buf[idx] = entry_buf[idx] ^ 8'(1 << $urandom_range(0, 7));
            end
            ENT_DELETED: entry_buf[fdes_pkg::PosFirst] = fdes_pkg::MarkDeleted;
            ENT_LFN:     entry_buf[fdes_pkg::PosAttr]  = fdes_pkg::AttrLfn;
            ENT_VOLUME:  entry_buf[fdes_pkg::PosAttr]  = 8'($urandom) | fdes_pkg::AttrVolume;
            ENT_END:     entry_buf[fdes_pkg::PosFirst] = fdes_pkg::MarkEnd;
            default: ;
        endcase
        entry_buf[fdes_pkg::PosClus2] = clus[23:16];
        entry_buf[fdes_pkg::PosClus3] = clus[31:24];
        entry_buf[fdes_pkg::PosClus0] = clus[7:0];
        entry_buf[fdes_pkg::PosClus1] = clus[15:8];
        entry_buf[fdes_pkg::PosSize0] = fsize[7:0];
        entry_buf[fdes_pkg::PosSize1] = fsize[15:8];
        entry_buf[fdes_pkg::PosSize2] = fsize[23:16];
        entry_buf[fdes_pkg::PosLast]  = fsize[31:24];
    endfunction

    // Offer one byte word; s_tvalid stays high after acceptance so that a
    // back-to-back word needs no second assignment in the same step.
    task automatic send_byte(logic [7:0] b, logic rs);
        int unsigned gap;
        gap = tx_idle ? $urandom_range(0, MaxGap) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= rs;
        do @(posedge aclk); while (s_tready !== 1'b1);
        predict_byte(b, rs);
        items_sent++;
    endtask

    task automatic send_entry(logic rs, int unsigned count);
        for (int i = 0; i < count; i++) send_byte(entry_buf[i], rs && i == 0);
    endtask

    // Drop s_tvalid and wait for every pending lookup, then let the pipe empty.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (lookup_q.size() != 0) @(posedge aclk);
        repeat (SettleCycles) @(posedge aclk);
    endtask

    task automatic write_reg(logic [fdes_pkg::CfgIdxW-1:0] idx,
                             logic [fdes_pkg::CfgDataW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
        @(posedge aclk);
        if (idx == fdes_pkg::RegNameLow) name_low = val;
        else if (idx == fdes_pkg::RegNameHigh) name_high = val[23:0];
    endtask

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %h, got %h", field, want, got);
            fail_count++;
        end
    endfunction

    // Result sink: random stall before each word while rx_idle is set, plus the long hold-off on request.
    initial begin : result_sink
        int unsigned hold;
        lookup_t     want;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            hold = rx_idle ? $urandom_range(0, MaxGap) : 0;
            if (hold_req != 0) begin
                hold     = hold_req;
                hold_req = 0;
            end
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 && hold_req == 0);
            if (m_tvalid === 1'b1) begin
                if (lookup_q.size() == 0) begin
                    $error("result word with no lookup pending: status %b tdata %h",
                           m_tuser, m_tdata);
                    fail_count++;
                end else begin
                    want = lookup_q.pop_front();
                    check_field("status", 32'(want.status), 32'(m_tuser));
                    check_field("first_cluster", want.cluster, m_tdata[31:0]);
                    check_field("file_size", want.size, m_tdata[63:32]);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CycleLimit) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Both name registers, upper garbage on the high one, and a write to an
    // index that must be dropped without touching the name.
    task automatic test_register_writes();
        write_reg(fdes_pkg::RegNameLow, ReadmeLow);
        write_reg(fdes_pkg::RegNameHigh, {40'hFF_FFFF_FFFF, ReadmeHigh});
        write_reg(RegUnmapped, '1);
    endtask

    // Plain hits with all-ones and all-zero cluster / size fields.
    task automatic test_found_entry();
        build_entry(ENT_MATCH, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_entry(1'b1, fdes_pkg::EntryLen);
        build_entry(ENT_MATCH, 32'h0, 32'h0);
        send_entry(1'b1, fdes_pkg::EntryLen);
    endtask

    // Deleted, long-name, volume-label and near-miss entries are passed over;
    // the hit six entries in also checks the position wrap.
    task automatic test_skipped_entries();
        build_entry(ENT_DELETED, $urandom, $urandom);
        send_entry(1'b1, fdes_pkg::EntryLen);
        build_entry(ENT_LFN, $urandom, $urandom);
        send_entry(1'b0, fdes_pkg::EntryLen);
        build_entry(ENT_VOLUME, $urandom, $urandom);
        entry_buf[fdes_pkg::PosAttr] = fdes_pkg::AttrVolume;
        send_entry(1'b0, fdes_pkg::EntryLen);
        build_entry(ENT_NEAR, $urandom, $urandom);
        send_entry(1'b0, fdes_pkg::EntryLen);
        build_entry(ENT_RANDOM, $urandom, $urandom);
        entry_buf[fdes_pkg::PosFirst] = 8'h41;   // keep it from reading as an end marker
        send_entry(1'b0, fdes_pkg::EntryLen);
        build_entry(ENT_MATCH, 32'h1234_5678, 32'h9ABC_DEF0);
        send_entry(1'b0, fdes_pkg::EntryLen);
    endtask

    // End marker on the restart byte, then an end marker behind a live entry.
    task automatic test_end_marker();
        build_entry(ENT_END, $urandom, $urandom);
        send_entry(1'b1, fdes_pkg::EntryLen);
        build_entry(ENT_NEAR, $urandom, $urandom);
        entry_buf[5] = fdes_pkg::MarkEnd;   // zero inside the name is not an end marker
        send_entry(1'b1, fdes_pkg::EntryLen);
        build_entry(ENT_END, $urandom, $urandom);
        send_entry(1'b0, fdes_pkg::EntryLen);
    endtask

    // Bytes after a result are dropped; a restart mid-entry starts over.
    task automatic test_restart_and_ignore();
        build_entry(ENT_MATCH, $urandom, $urandom);
        send_entry(1'b1, fdes_pkg::EntryLen);
        repeat (20) send_byte(8'($urandom), 1'b0);
        build_entry(ENT_MATCH, $urandom, $urandom);
        send_entry(1'b1, 15);
        build_entry(ENT_MATCH, $urandom, $urandom);
        send_entry(1'b1, fdes_pkg::EntryLen);
    endtask

    // Receiver holds off for a long stretch while hits keep streaming in, so
    // the byte queue fills and s_tready must drop.
    task automatic test_backpressure();
        settle();
        tx_idle  = 1'b0;
        hold_req = LongHold;
        repeat (3) begin
            build_entry(ENT_MATCH, $urandom, $urandom);
            send_entry(1'b1, fdes_pkg::EntryLen);
        end
        settle();
        tx_idle = 1'b1;
    endtask

    // One search: restart, a few filler entries, then a hit, an end marker or
    // a random tail, sometimes cut short. Now and then raw noise instead.
    task automatic run_one_search();
        int unsigned fillers;
        int unsigned roll;
        entry_kind_t tail;
        if ($urandom_range(0, 7) == 0) tx_idle = ~tx_idle;
        if ($urandom_range(0, 7) == 0) rx_idle = ~rx_idle;
        if ($urandom_range(0, 15) == 0) settle();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 40)) send_byte(8'($urandom), $urandom_range(0, 7) == 0);
        end else begin
            fillers = $urandom_range(0, 3);
            for (int k = 0; k < fillers; k++) begin
                build_entry(entry_kind_t'($urandom_range(ENT_NEAR, ENT_RANDOM)),
                            $urandom, $urandom);
                send_entry(k == 0, fdes_pkg::EntryLen);
            end
            roll = $urandom_range(0, 99);
            tail = roll < 50 ? ENT_MATCH : (roll < 85 ? ENT_END : ENT_RANDOM);
            build_entry(tail, $urandom, $urandom);
            send_entry(fillers == 0,
                       $urandom_range(0, 9) == 0 ? $urandom_range(1, fdes_pkg::EntryLen - 1)
                                                 : fdes_pkg::EntryLen);
        end
    endtask

    // Five name settings: all zeros, all ones, printable, then fully random.
    task automatic test_random_searches();
        logic [63:0] lo;
        logic [63:0] hi;
        int unsigned start_items;
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            case (ph)
                0: begin
                    lo = '0;
                    hi = '0;
                end
                1: begin
                    lo = '1;
                    hi = '1;
                end
                2: begin
                    for (int i = 0; i < 8; i++) lo[8*i +: 8] = 8'($urandom_range(8'h20, 8'h5A));
                    hi = {$urandom, $urandom};
                    for (int i = 0; i < 3; i++) hi[8*i +: 8] = 8'($urandom_range(8'h20, 8'h5A));
                end
                default: begin
                    lo = {$urandom, $urandom};
                    hi = {$urandom, $urandom};
                end
            endcase
            write_reg(fdes_pkg::RegNameLow, lo);
            write_reg(fdes_pkg::RegNameHigh, hi);
            start_items = items_sent;
            while (items_sent - start_items < PhaseBytes) run_one_search();
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_register_writes();
        test_found_entry();
        test_skipped_entries();
        test_end_marker();
        test_restart_and_ignore();
        test_backpressure();
        test_random_searches();
        settle();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
